// ===== design/morton_key_2d_from_position_unit_assert.svh =====
// Assertion macros for the Morton key unit.
// Included by modules that check their own pipeline; relies on clock and reset ports.
`ifndef MORTON_KEY_2D_FROM_POSITION_UNIT_ASSERT_SVH
`define MORTON_KEY_2D_FROM_POSITION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// cond at one edge implies expr at the next edge
`define MK2D_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("mk2d: next-cycle check failed");
// cond implies expr at the same edge
`define MK2D_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("mk2d: same-cycle check failed");
`else
`define MK2D_ASSERT_NEXT(label, cond, expr)
`define MK2D_ASSERT_SAME(label, cond, expr)
`endif
`endif

// ===== design/mk2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and the bit-interleave function for the Morton key unit.
// No dependencies.
package mk2d_pkg;

   localparam int GRID_BITS  = 18;
   localparam int KEY_W      = 2 * GRID_BITS;
   localparam int POS_W      = 32;
   localparam int SCALE_W    = 48;
   localparam int SCALE_LO_W = 32;
   localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
   localparam int HI_PROD_W  = POS_W + SCALE_HI_W;
   localparam int SUM_W      = HI_PROD_W + 1;
   localparam int STAGES     = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SCALE_W-1:0]   SCALE_RESET = 48'h0003_FFFF_0000;
   localparam logic [GRID_BITS-1:0] CELL_MAX    = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X   = 2'd0,
      REG_ORIGIN_Y   = 2'd1,
      REG_GRID_SCALE = 2'd2
   } csr_index_type;

   typedef logic [GRID_BITS-1:0] cell_type;
   typedef logic [KEY_W-1:0]     key_type;

   // x cell bits land on even key bits, y cell bits on odd key bits
   function automatic key_type interleave(input cell_type x, input cell_type y);
      key_type k;
      k = '0;
      for (int i = 0; i < GRID_BITS; i++) begin
         k[2*i]     = x[i];
         k[2*i + 1] = y[i];
      end
      return k;
   endfunction

endpackage

// ===== design/morton_key_2d_from_position_unit.sv =====
`timescale 1ns / 1ps
// Morton key unit top level: CSRs, input register, valid pipeline, interleave and result register.
// Depends on mk2d_pkg, mk2d_cell and the assertion macro header.
//
// Takes one position word per cycle while req_ready is high and returns one 36-bit key word per position, in order.
// A key appears on rsp_key after its position passes, in order, one input register,
// the offset stage, the registered 32x32 and 32x16 multiplies, the sum and saturate stage,
// and the result register. The whole pipeline advances together whenever the result
// register is empty or being taken, so req_ready drops only while a key waits on rsp_ready.
// Write origin_x, origin_y and grid_scale only while no words are in flight.
`include "morton_key_2d_from_position_unit_assert.svh"
module morton_key_2d_from_position_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mk2d_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [mk2d_pkg::POS_W-1:0]      req_pos_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [mk2d_pkg::KEY_W-1:0]      rsp_key,
   input  logic                                   csr_wr_en,
   input  logic        [mk2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [mk2d_pkg::SCALE_W-1:0]    csr_wdata
);

   logic signed [mk2d_pkg::POS_W-1:0]   origin_x_ff, origin_y_ff;
   logic        [mk2d_pkg::SCALE_W-1:0] scale_ff;
   logic signed [mk2d_pkg::POS_W-1:0]   pos_x_ff, pos_y_ff;
   logic        [mk2d_pkg::STAGES-1:0]  vld_ff, vld_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   mk2d_pkg::key_type                   key_ff;
   mk2d_pkg::cell_type                  cell_x, cell_y;
   logic                                adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_ff    <= mk2d_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         case (mk2d_pkg::csr_index_type'(csr_index))
            mk2d_pkg::REG_ORIGIN_X:   origin_x_ff <= csr_wdata[mk2d_pkg::POS_W-1:0];
            mk2d_pkg::REG_ORIGIN_Y:   origin_y_ff <= csr_wdata[mk2d_pkg::POS_W-1:0];
            mk2d_pkg::REG_GRID_SCALE: scale_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance the pipe unless a finished word is stuck at the output
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      vld_in       = {vld_ff[mk2d_pkg::STAGES-2:0], req_valid};
      rsp_valid_in = vld_ff[mk2d_pkg::STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         key_ff   <= mk2d_pkg::interleave(cell_x, cell_y);
      end
   end

   mk2d_cell u_cell_x (
      .clock    (clock),
      .en       (adv),
      .pos      (pos_x_ff),
      .origin   (origin_x_ff),
      .scale    (scale_ff),
      .cell_idx (cell_x)
   );

   mk2d_cell u_cell_y (
      .clock    (clock),
      .en       (adv),
      .pos      (pos_y_ff),
      .origin   (origin_y_ff),
      .scale    (scale_ff),
      .cell_idx (cell_y)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key   = key_ff;

   `MK2D_ASSERT_NEXT(a_accept_enters_pipe, req_valid && req_ready, vld_ff[0])
   `MK2D_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(vld_ff) && $stable(cell_x))
   `MK2D_ASSERT_SAME(a_rsp_from_last_stage, $rose(rsp_valid), $past(vld_ff[mk2d_pkg::STAGES-1]))

endmodule

// ===== design/mk2d_cell.sv =====
`timescale 1ns / 1ps
// One coordinate's cell-index pipeline: offset, split multiply, sum and saturate.
// Depends on mk2d_pkg.
module mk2d_cell (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [mk2d_pkg::POS_W-1:0]   pos,
   input  logic signed [mk2d_pkg::POS_W-1:0]   origin,
   input  logic        [mk2d_pkg::SCALE_W-1:0] scale,
   output mk2d_pkg::cell_type                  cell_idx
);

   // stage 1: offset from origin
   logic signed [mk2d_pkg::POS_W:0]         diff;
   logic [mk2d_pkg::POS_W-1:0]              off_in, off_ff;
   logic                                    above_in, above_ff;
   // stage 2: partial products
   logic [2*mk2d_pkg::POS_W-1:0]            lo_full;
   logic [mk2d_pkg::POS_W-1:0]              lo_in, lo_ff;
   logic [mk2d_pkg::HI_PROD_W-1:0]          hi_in, hi_ff;
   logic                                    above2_ff;
   // stage 3: cell index
   logic [mk2d_pkg::SUM_W-1:0]              sum;
   mk2d_pkg::cell_type                      cell_in, cell_ff;

   always_comb begin
      diff     = {pos[mk2d_pkg::POS_W-1], pos} - {origin[mk2d_pkg::POS_W-1], origin};
      above_in = !diff[mk2d_pkg::POS_W] && (diff != '0);
      off_in   = diff[mk2d_pkg::POS_W-1:0];
   end

   always_comb begin
      lo_full = off_ff * scale[mk2d_pkg::SCALE_LO_W-1:0];
      lo_in   = lo_full[2*mk2d_pkg::POS_W-1:mk2d_pkg::POS_W];
      hi_in   = off_ff * scale[mk2d_pkg::SCALE_W-1:mk2d_pkg::SCALE_LO_W];
   end

   always_comb begin
      sum = {1'b0, hi_ff} + {{(mk2d_pkg::SUM_W - mk2d_pkg::POS_W){1'b0}}, lo_ff};
      if (!above2_ff) begin
         cell_in = '0;
      end else if (|sum[mk2d_pkg::SUM_W-1:mk2d_pkg::GRID_BITS]) begin
         cell_in = mk2d_pkg::CELL_MAX;
      end else begin
         cell_in = sum[mk2d_pkg::GRID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff    <= off_in;
         above_ff  <= above_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         above2_ff <= above_ff;
         cell_ff   <= cell_in;
      end
   end

   assign cell_idx = cell_ff;

endmodule

// ===== tb/mk2d_key_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Morton key unit: mirrors the CSRs, predicts one key per accepted position word
// and compares each accepted key word in order. Depends on mk2d_pkg.
module mk2d_key_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic        [mk2d_pkg::POS_W-1:0]     req_pos_x,
   input  logic        [mk2d_pkg::POS_W-1:0]     req_pos_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic        [mk2d_pkg::KEY_W-1:0]     rsp_key,
   input  logic                                  csr_wr_en,
   input  logic        [mk2d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mk2d_pkg::SCALE_W-1:0]   csr_wdata,
   output int                                    fail_count,
   output int                                    keys_pending
);
   import mk2d_pkg::*;

   // the product of offset and scale is Q48.32; the cell index is its integer part
   localparam int PRODUCT_SHIFT = 32;

   logic [POS_W-1:0]   origin_x_q = '0;
   logic [POS_W-1:0]   origin_y_q = '0;
   logic [SCALE_W-1:0] scale_q    = SCALE_RESET;
   key_type            key_queue[$];
   int                 failures   = 0;

   function automatic cell_type cell_of(input logic [POS_W-1:0] pos,
                                        input logic [POS_W-1:0] origin);
      logic [POS_W+1:0]         diff;
      logic [POS_W+SCALE_W-1:0] product;
      logic [POS_W+SCALE_W-1:0] whole;
      diff = {{2{pos[POS_W-1]}}, pos} - {{2{origin[POS_W-1]}}, origin};
      // clamp positions at or left of the origin to cell 0
      if (diff[POS_W+1] || diff == '0)
         return '0;
      product = diff[POS_W-1:0] * scale_q;
      whole   = product >> PRODUCT_SHIFT;
      if (whole > CELL_MAX)
         return CELL_MAX;
      return whole[GRID_BITS-1:0];
   endfunction

   // build the key from the top cell bit down, two key bits per step
   function automatic key_type morton_of(input cell_type cx, input cell_type cy);
      key_type k;
      k = '0;
      for (int i = GRID_BITS - 1; i >= 0; i--)
         k = {k[KEY_W-3:0], cy[i], cx[i]};
      return k;
   endfunction

   always @(posedge clock) begin
      key_type predicted;
      if (reset) begin
         origin_x_q = '0;
         origin_y_q = '0;
         scale_q    = SCALE_RESET;
         key_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ORIGIN_X:   origin_x_q = csr_wdata[POS_W-1:0];
               REG_ORIGIN_Y:   origin_y_q = csr_wdata[POS_W-1:0];
               REG_GRID_SCALE: scale_q    = csr_wdata;
               default: ;  // drop writes to unmapped indexes
            endcase
         end
         if (req_valid && req_ready)
            key_queue.push_back(morton_of(cell_of(req_pos_x, origin_x_q),
                                          cell_of(req_pos_y, origin_y_q)));
         if (rsp_valid && rsp_ready) begin
            if (key_queue.size() == 0) begin
               $display("%0t: key word %h arrived with no position pending", $time, rsp_key);
               failures++;
            end else begin
               predicted = key_queue.pop_front();
               if (rsp_key !== predicted) begin
                  $display("%0t: key mismatch: expected %h actual %h",
                           $time, predicted, rsp_key);
                  failures++;
               end
            end
         end
      end
      keys_pending <= key_queue.size();
      fail_count   <= failures;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the Morton key unit testbench: clock, reset, CSR programming, position stimulus,
// key backpressure and the verdict. Depends on mk2d_pkg, the unit and mk2d_key_checker.
module tb_top;
   import mk2d_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int     RESET_CYCLES    = 8;
   localparam int     SETTLE_CYCLES   = 8;
   localparam int     WATCHDOG_LIMIT  = 4000;
   localparam int     RANDOM_PHASES   = 12;
   localparam int     ITEMS_PER_PHASE = 90;
   localparam longint POS_MAX         = 64'sd2147483647;
   localparam longint POS_MIN         = -64'sd2147483648;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_valid  = 1'b0;
   logic                        req_ready;
   logic signed [POS_W-1:0]     req_pos_x  = '0;
   logic signed [POS_W-1:0]     req_pos_y  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready  = 1'b0;
   logic        [KEY_W-1:0]     rsp_key;
   logic                        csr_wr_en  = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index  = '0;
   logic        [SCALE_W-1:0]   csr_wdata  = '0;

   int   fail_count;
   int   keys_pending;
   logic no_idle      = 1'b0;
   int   stall_left   = 0;
   int   quiet_cycles = 0;

   morton_key_2d_from_position_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_key   (rsp_key),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mk2d_key_checker u_key_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_key      (rsp_key),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .keys_pending (keys_pending)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input longint v);
      if (v > POS_MAX)
         v = POS_MAX;
      if (v < POS_MIN)
         v = POS_MIN;
      return v[POS_W-1:0];
   endfunction

   // mostly inside the region widened by a margin on both sides, some at its edges, some anywhere
   function automatic logic [POS_W-1:0] region_pos(input longint org, input longint extent);
      logic [63:0] rnd;
      int          pick;
      pick = $urandom_range(0, 99);
      rnd  = {$urandom, $urandom};
      if (pick < 10)
         return rnd[POS_W-1:0];
      if (pick < 20)
         return clamp_pos((pick < 15 ? org : org + extent) + longint'($urandom_range(0, 2)) - 1);
      return clamp_pos(org - extent / 8 + longint'(rnd % (extent + extent / 4 + 1)));
   endfunction

   // key side: random stalls unless in a no-idle stretch
   always @(posedge clock) begin
      logic next_ready;
      if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
         next_ready = 1'b1;
      end else begin
         stall_left = gap_length() - 1;
         next_ready = 1'b0;
      end
      rsp_ready <= next_ready;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_position(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      int gap;
      gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every pending key has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (keys_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_region(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                                 input logic [SCALE_W-1:0] scale);
      drain();
      csr_wr_en <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= SCALE_W'({$urandom, $urandom});
         @(posedge clock);
      end
      // upper data bits are don't-care for the origins; fill them with noise
      csr_index <= REG_ORIGIN_X;
      csr_wdata <= {16'($urandom), ox};
      @(posedge clock);
      csr_index <= REG_ORIGIN_Y;
      csr_wdata <= {16'($urandom), oy};
      @(posedge clock);
      csr_index <= REG_GRID_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      longint             extent;
      longint             org_x;
      longint             org_y;
      logic [SCALE_W-1:0] scale;
      int                 pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset setting: unit region, one Q16.16 unit spans all cells
      send_position(32'h0000_0000, 32'h0000_0000);
      send_position(32'h0000_0001, 32'h0000_0001);
      send_position(32'h0000_FFFF, 32'h0000_FFFF);
      send_position(32'h0001_0000, 32'h0001_0000);
      send_position(32'h0000_8000, 32'h0000_4000);
      send_position(32'hFFFF_FFFF, 32'h0000_0001);
      send_position(32'h8000_0000, 32'h7FFF_FFFF);
      send_position(32'h7FFF_FFFF, 32'h8000_0000);
      send_position(32'h0000_5555, 32'h0000_AAAA);

      program_region(32'h8000_0000, 32'h7FFF_FFFF, '1);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 32'h8000_0000);
      send_position(32'h8000_0001, 32'h7FFF_FFFE);

      program_region(32'h7FFF_FFFF, 32'h8000_0000, 48'h0000_0000_0001);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 32'h8000_0000);

      program_region(32'h0000_0000, 32'h0000_0000, '0);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h0000_0001, 32'h0001_0000);

      // one cell per raw unit: probe the saturation boundary
      program_region(32'h0000_0000, 32'h0000_0000, 48'h0001_0000_0000);
      send_position(32'd262143, 32'd262142);
      send_position(32'd262144, 32'd131071);
      send_position(32'd262145, 32'd262143);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         extent = longint'(1) << $urandom_range(2, 31);
         extent = extent + longint'($urandom) % extent;
         pick   = $urandom_range(0, 99);
         if (pick < 10)
            org_x = POS_MIN;
         else if (pick < 20)
            org_x = POS_MAX - extent;
         else
            org_x = longint'($signed($urandom));
         org_y = longint'($signed($urandom));
         pick  = $urandom_range(0, 99);
         if (pick < 5)
            scale = '0;
         else if (pick < 12)
            scale = SCALE_W'({$urandom, $urandom});
         else if (pick < 16)
            scale = '1;
         else
            scale = SCALE_W'((longint'(CELL_MAX) << 32) / extent);
         program_region(org_x[POS_W-1:0], org_y[POS_W-1:0], scale);
         no_idle <= (phase % 4 == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_position(region_pos(org_x, extent), region_pos(org_y, extent));
      end

      drain();
      if (fail_count == 0 && keys_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
